/* hw/rtl/text_pretokenizer_splitter_core_defines.svh */
// assertion macros shared by the pre-tokenizer rtl
`ifndef TEXT_PRETOKENIZER_SPLITTER_CORE_DEFINES_SVH
`define TEXT_PRETOKENIZER_SPLITTER_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define TPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off while reset is low
`define TPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tps_pkg.sv */
// shared types, character constants and class functions of the pre-tokenizer
package tps_pkg;

  localparam int WS_DEPTH_DEF = 16;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_APOS  = 8'd39;
  localparam logic [7:0] CH_R     = 8'd114;
  localparam logic [7:0] CH_V     = 8'd118;
  localparam logic [7:0] CH_L     = 8'd108;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } tps_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_start;
    logic       run_last;
    logic       text_done;
    logic       ws_truncated;
  } tps_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPACE, ST_ALPHA, ST_DIGIT, ST_PUNCT,
    ST_CONTR1, ST_CONTR2, ST_CONTR3, ST_WSRUN
  } scan_state_t;

  typedef enum logic [2:0] {
    EMIT_NONE, EMIT_ONE, EMIT_TWO, EMIT_FLUSH, EMIT_EMPTY
  } emit_kind_t;

  // what the scanner decided for the item in the item register
  typedef struct packed {
    emit_kind_t kind;
    logic [7:0] byte0;
    logic       start0;
    logic       push;
    logic       trunc;
  } scan_dec_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

endpackage

/* hw/rtl/text_pretokenizer_splitter_core.sv */
// an accepted item is held in the item register and its results are offered from the skid output register
// throughput: one item per cycle while the output skid entry is free; an item with
//   several results (joined space, trailing whitespace flush) holds the input until its last result is taken
// whitespace flush reads one stored byte per cycle, while the output takes results, from the run store read port
// reset: synchronous active-low rst_n returns the scanner to idle at a token start
`include "text_pretokenizer_splitter_core_defines.svh"

module text_pretokenizer_splitter_core #(
  parameter int WS_DEPTH = tps_pkg::WS_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tps_pkg::tps_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output tps_pkg::tps_out_t out_item
);
  import tps_pkg::*;

  localparam int MAX_RES = (WS_DEPTH < 2) ? 2 : WS_DEPTH;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int AW      = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  logic             item_valid_r;
  tps_in_t          item_r;
  logic [CNT_W-1:0] ph_r;

  scan_dec_t        dec;
  logic [CNT_W-1:0] ws_base, flush_cnt, n_res, rd_idx;
  logic             emit, up_ready, emit_fire, last, done;
  logic [7:0]       rd_data;
  tps_out_t         res;

  tps_scan #(.WS_DEPTH(WS_DEPTH)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item_r),
    .commit    (done),
    .dec       (dec),
    .ws_base   (ws_base),
    .flush_cnt (flush_cnt)
  );

  always_comb begin
    case (dec.kind)
      EMIT_ONE:   n_res = CNT_W'(1);
      EMIT_TWO:   n_res = CNT_W'(2);
      EMIT_FLUSH: n_res = flush_cnt;
      EMIT_EMPTY: n_res = CNT_W'(1);
      default:    n_res = '0;
    endcase
  end

  assign emit      = item_valid_r && dec.kind != EMIT_NONE;
  assign emit_fire = emit && up_ready;
  assign last      = (ph_r == n_res - CNT_W'(1));
  assign done      = item_valid_r && (dec.kind == EMIT_NONE || (up_ready && last));
  assign in_ready  = !item_valid_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      ph_r         <= '0;
    end else if (in_valid && in_ready) begin
      item_valid_r <= 1'b1;
      ph_r         <= '0;
    end else if (done) begin
      item_valid_r <= 1'b0;
      ph_r         <= '0;
    end else if (emit_fire) begin
      ph_r <= ph_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  // keep the read data one step ahead of the flush position
  always_comb begin
    if (item_valid_r && !done) begin
      rd_idx = emit_fire ? ph_r + CNT_W'(1) : ph_r;
    end else begin
      rd_idx = '0;
    end
  end

  tps_ws_buf #(.WS_DEPTH(WS_DEPTH)) u_ws_buf (
    .clk     (clk),
    .wr_en   (done && dec.push),
    .wr_addr (ws_base[AW-1:0]),
    .wr_data (item_r.in_byte),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    res.out_byte     = item_r.in_byte;
    res.byte_valid   = 1'b1;
    res.token_start  = 1'b0;
    res.run_last     = last;
    res.text_done    = last && item_r.end_of_text;
    res.ws_truncated = 1'b0;
    case (dec.kind)
      EMIT_FLUSH: begin
        // the byte of this item is not in the store yet
        res.out_byte     = (ph_r == ws_base) ? item_r.in_byte : rd_data;
        res.token_start  = (ph_r == '0);
        res.ws_truncated = dec.trunc;
      end
      EMIT_EMPTY: begin
        res.out_byte   = '0;
        res.byte_valid = 1'b0;
      end
      EMIT_ONE, EMIT_TWO: begin
        if (ph_r == '0) begin
          res.out_byte    = dec.byte0;
          res.token_start = dec.start0;
        end
      end
      default: begin
        res.run_last = 1'b0;
      end
    endcase
  end

  tps_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (emit),
    .up_ready  (up_ready),
    .up_data   (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_item)
  );

  `TPS_ASSERT_NOW(a_phase_in_range, clk, rst_n, emit, ph_r < n_res, "result index past item count")
  `TPS_ASSERT_NEXT(a_eot_clears_run, clk, rst_n, done && item_r.end_of_text, ws_base == '0, "run not cleared after end of text")
  `TPS_ASSERT_NEXT(a_phase_steps, clk, rst_n, emit_fire && !last, item_valid_r && ph_r == $past(ph_r) + CNT_W'(1), "result index did not advance")

endmodule

/* hw/rtl/tps_ws_buf.sv */
// trailing whitespace run store, one write and one registered read port
module tps_ws_buf #(
  parameter int WS_DEPTH = tps_pkg::WS_DEPTH_DEF,
  localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import tps_pkg::*;

  logic [7:0] mem [WS_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_addr) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/tps_scan.sv */
// byte classifier and token scanner state, decides the results of one item
module tps_scan #(
  parameter int WS_DEPTH = tps_pkg::WS_DEPTH_DEF,
  localparam int MAX_RES = (WS_DEPTH < 2) ? 2 : WS_DEPTH,
  localparam int CNT_W = $clog2(MAX_RES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tps_pkg::tps_in_t   item,
  input  logic               commit,
  output tps_pkg::scan_dec_t dec,
  output logic [CNT_W-1:0]   ws_base,
  output logic [CNT_W-1:0]   flush_cnt
);
  import tps_pkg::*;

  scan_state_t      state_r, state_nxt, st_step, tok_state, bnd_state;
  logic             aposl_r, aposl_nxt, aposl_step;
  logic [CNT_W-1:0] ws_count_r, cnt_nxt, cnt_step;
  logic             ws_ovf_r, ovf_nxt, ovf_step;
  logic [7:0]       cur_byte;
  logic             eot, c_ws, c_alpha, c_digit, c_punct;
  logic             take_bnd, push;
  logic [1:0]       n_imm;
  logic [7:0]       byte0;
  logic             start0;

  assign cur_byte = item.in_byte;
  assign eot      = item.end_of_text;
  assign c_ws     = is_ws(cur_byte);
  assign c_alpha  = is_alpha(cur_byte);
  assign c_digit  = is_digit(cur_byte);
  assign c_punct  = !c_ws && !c_alpha && !c_digit;

  always_comb begin
    if (cur_byte == CH_APOS && !eot) begin
      tok_state = ST_CONTR1;
    end else if (c_alpha) begin
      tok_state = ST_ALPHA;
    end else if (c_digit) begin
      tok_state = ST_DIGIT;
    end else begin
      tok_state = ST_PUNCT;
    end
  end

  always_comb begin
    if (cur_byte == CH_SPACE) begin
      bnd_state = ST_SPACE;
    end else if (c_ws) begin
      bnd_state = ST_IDLE;
    end else begin
      bnd_state = tok_state;
    end
  end

  assign ws_base = (state_r == ST_SPACE) ? '0 : ws_count_r;

  // per-state step
  always_comb begin
    st_step    = state_r;
    aposl_step = aposl_r;
    cnt_step   = ws_count_r;
    ovf_step   = ws_ovf_r;
    take_bnd   = 1'b0;
    n_imm      = 2'd0;
    byte0      = cur_byte;
    start0     = 1'b0;
    push       = 1'b0;
    case (state_r)
      ST_SPACE: begin
        if (c_ws) begin
          cnt_step = CNT_W'(1);
          ovf_step = 1'b0;
          push     = 1'b1;
          st_step  = ST_WSRUN;
        end else begin
          // pending space opens the token, the byte joins it
          n_imm   = 2'd2;
          byte0   = CH_SPACE;
          start0  = 1'b1;
          st_step = tok_state;
        end
      end
      ST_ALPHA: begin
        if (c_alpha) begin
          n_imm = 2'd1;
        end else begin
          take_bnd = 1'b1;
        end
      end
      ST_DIGIT: begin
        if (c_digit) begin
          n_imm = 2'd1;
        end else begin
          take_bnd = 1'b1;
        end
      end
      ST_PUNCT: begin
        if (c_punct) begin
          n_imm = 2'd1;
        end else begin
          take_bnd = 1'b1;
        end
      end
      ST_CONTR1: begin
        n_imm = 2'd1;
        if ((cur_byte == CH_R || cur_byte == CH_V || cur_byte == CH_L) && !eot) begin
          aposl_step = (cur_byte == CH_L);
          st_step    = ST_CONTR2;
        end else begin
          st_step = ST_IDLE;
        end
      end
      ST_CONTR2: begin
        n_imm      = 2'd1;
        st_step    = (aposl_r && !eot) ? ST_CONTR3 : ST_IDLE;
        aposl_step = 1'b0;
      end
      ST_CONTR3: begin
        if (cur_byte == CH_L) begin
          n_imm   = 2'd1;
          st_step = ST_IDLE;
        end else begin
          take_bnd = 1'b1;
        end
      end
      ST_WSRUN: begin
        if (c_ws) begin
          if (ws_count_r < CNT_W'(WS_DEPTH)) begin
            push     = 1'b1;
            cnt_step = ws_count_r + CNT_W'(1);
          end else begin
            ovf_step = 1'b1;
          end
        end else begin
          cnt_step = '0;
          ovf_step = 1'b0;
          take_bnd = 1'b1;
        end
      end
      default: begin
        take_bnd = 1'b1;
      end
    endcase
    if (take_bnd) begin
      st_step = bnd_state;
      n_imm   = {1'b0, !c_ws};
      start0  = 1'b1;
    end
  end

  // end of text closes whatever is pending and returns to reset
  always_comb begin
    dec.byte0  = byte0;
    dec.start0 = start0;
    dec.push   = push;
    dec.trunc  = ovf_step;
    state_nxt  = st_step;
    aposl_nxt  = aposl_step;
    cnt_nxt    = cnt_step;
    ovf_nxt    = ovf_step;
    case (n_imm)
      2'd1:    dec.kind = EMIT_ONE;
      2'd2:    dec.kind = EMIT_TWO;
      default: dec.kind = EMIT_NONE;
    endcase
    if (eot) begin
      if (st_step == ST_SPACE) begin
        dec.kind   = EMIT_ONE;
        dec.byte0  = CH_SPACE;
        dec.start0 = 1'b1;
      end else if (st_step == ST_WSRUN) begin
        dec.kind = EMIT_FLUSH;
      end else if (n_imm == 2'd0) begin
        dec.kind = EMIT_EMPTY;
      end
      state_nxt = ST_IDLE;
      aposl_nxt = 1'b0;
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  assign flush_cnt = cnt_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      aposl_r    <= 1'b0;
      ws_count_r <= '0;
      ws_ovf_r   <= 1'b0;
    end else if (commit) begin
      state_r    <= state_nxt;
      aposl_r    <= aposl_nxt;
      ws_count_r <= cnt_nxt;
      ws_ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* hw/rtl/tps_out_skid.sv */
// result output register with a skid entry, ready to the producer is registered
module tps_out_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  tps_pkg::tps_out_t up_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tps_pkg::tps_out_t out_data
);
  import tps_pkg::*;

  logic     out_valid_r, skid_valid_r;
  tps_out_t out_data_r, skid_data_r;
  logic     stalled, up_fire;

  assign up_ready = !skid_valid_r;
  assign stalled  = out_valid_r && !out_ready;
  assign up_fire  = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (stalled) begin
      if (up_fire) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stalled) begin
      if (up_fire) begin
        skid_data_r <= up_data;
      end
    end else if (skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (up_fire) begin
      out_data_r <= up_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/text_pretokenizer_splitter_core_test.sv */
// self-checking testbench for the byte-stream pre-tokenizer splitter core
`timescale 1ns / 1ps

module text_pretokenizer_splitter_core_test;
  import tps_pkg::*;

  localparam int WS_DEPTH      = WS_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 460;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    tps_in_t item;
    bit      wait_drain;
  } pending_byte_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  tps_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tps_out_t out_item;

  text_pretokenizer_splitter_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  pending_byte_t text_pending[$];
  tps_out_t      step_pieces[$];
  tps_out_t      expected_pieces[$];
  int            total_items    = 0;
  int            accepted_count = 0;
  int            pieces_due     = 0;
  int            pieces_seen    = 0;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  bit            drain_next     = 1'b0;

  // splitter state as the block should hold it
  scan_state_t scan_q       = ST_IDLE;
  logic        apos_l_q     = 1'b0;
  logic [7:0]  run_store [WS_DEPTH];
  int          run_count    = 0;
  logic        run_overflow = 1'b0;

  function automatic logic ws_class(input logic [7:0] ch);
    return ch == CH_SPACE || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic logic letter_class(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  function automatic logic digit_class(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic void emit_piece(input logic [7:0] ch, input logic vld, input logic st,
                                     input logic tr);
    tps_out_t p;
    p = '0;
    p.out_byte     = ch;
    p.byte_valid   = vld;
    p.token_start  = st;
    p.ws_truncated = tr;
    step_pieces.insert(step_pieces.size(), p);
  endfunction

  function automatic void open_token(input logic [7:0] ch, input logic eot);
    emit_piece(ch, 1'b1, 1'b1, 1'b0);
    if (ch == CH_APOS && !eot) begin
      scan_q = ST_CONTR1;
    end else if (letter_class(ch)) begin
      scan_q = ST_ALPHA;
    end else if (digit_class(ch)) begin
      scan_q = ST_DIGIT;
    end else begin
      scan_q = ST_PUNCT;
    end
  endfunction

  function automatic void at_boundary(input logic [7:0] ch, input logic eot);
    if (ch == CH_SPACE) begin
      scan_q = ST_SPACE;
    end else if (ws_class(ch)) begin
      scan_q = ST_IDLE;
    end else begin
      open_token(ch, eot);
    end
  endfunction

  function automatic void run_push(input logic [7:0] ch);
    if (run_count < WS_DEPTH) begin
      run_store[run_count] = ch;
      run_count++;
    end else begin
      run_overflow = 1'b1;
    end
  endfunction

  // works out the pieces one accepted item gives and advances the state
  function automatic void split_text_byte(input tps_in_t it);
    logic [7:0] ch;
    logic       eot;
    ch  = it.in_byte;
    eot = it.end_of_text;
    step_pieces.delete();
    case (scan_q)
      ST_SPACE: begin
        if (ws_class(ch)) begin
          run_count    = 0;
          run_overflow = 1'b0;
          run_push(ch);
          scan_q = ST_WSRUN;
        end else begin
          // the pending space opens the token, the byte joins it
          emit_piece(CH_SPACE, 1'b1, 1'b1, 1'b0);
          open_token(ch, eot);
          step_pieces[$].token_start = 1'b0;
        end
      end
      ST_ALPHA: begin
        if (letter_class(ch)) emit_piece(ch, 1'b1, 1'b0, 1'b0);
        else at_boundary(ch, eot);
      end
      ST_DIGIT: begin
        if (digit_class(ch)) emit_piece(ch, 1'b1, 1'b0, 1'b0);
        else at_boundary(ch, eot);
      end
      ST_PUNCT: begin
        if (!ws_class(ch) && !letter_class(ch) && !digit_class(ch)) begin
          emit_piece(ch, 1'b1, 1'b0, 1'b0);
        end else begin
          at_boundary(ch, eot);
        end
      end
      ST_CONTR1: begin
        emit_piece(ch, 1'b1, 1'b0, 1'b0);
        if ((ch == CH_R || ch == CH_V || ch == CH_L) && !eot) begin
          apos_l_q = (ch == CH_L);
          scan_q   = ST_CONTR2;
        end else begin
          scan_q = ST_IDLE;
        end
      end
      ST_CONTR2: begin
        emit_piece(ch, 1'b1, 1'b0, 1'b0);
        scan_q   = (apos_l_q && !eot) ? ST_CONTR3 : ST_IDLE;
        apos_l_q = 1'b0;
      end
      ST_CONTR3: begin
        if (ch == CH_L) begin
          emit_piece(ch, 1'b1, 1'b0, 1'b0);
          scan_q = ST_IDLE;
        end else begin
          at_boundary(ch, eot);
        end
      end
      ST_WSRUN: begin
        if (ws_class(ch)) begin
          run_push(ch);
        end else begin
          run_count    = 0;
          run_overflow = 1'b0;
          at_boundary(ch, eot);
        end
      end
      default: at_boundary(ch, eot);
    endcase

    if (eot) begin
      if (scan_q == ST_SPACE) begin
        emit_piece(CH_SPACE, 1'b1, 1'b1, 1'b0);
      end else if (scan_q == ST_WSRUN) begin
        for (int i = 0; i < run_count; i++)
          emit_piece(run_store[i], 1'b1, i == 0, run_overflow);
      end
      if (step_pieces.size() == 0) emit_piece(8'd0, 1'b0, 1'b0, 1'b0);
      step_pieces[$].text_done = 1'b1;
      scan_q       = ST_IDLE;
      apos_l_q     = 1'b0;
      run_count    = 0;
      run_overflow = 1'b0;
    end
    if (step_pieces.size() > 0) step_pieces[$].run_last = 1'b1;
    foreach (step_pieces[i]) expected_pieces.insert(expected_pieces.size(), step_pieces[i]);
  endfunction

  function automatic int load_phase(input int n);
    if (n < total_items / 3) return 0;
    if (n < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  function automatic int sender_idle_pct(input int n);
    case (load_phase(n))
      0:       return 34;
      1:       return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(input int n);
    case (load_phase(n))
      0:       return 51;
      1:       return 34;
      default: return 0;
    endcase
  endfunction

  // driver: presents queued items and predicts on acceptance
  always @(posedge clk) begin
    logic          nxt_valid;
    tps_in_t       nxt_item;
    logic          took;
    pending_byte_t head;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_item  = in_item;
      took      = in_valid && in_ready;
      if (took) begin
        split_text_byte(in_item);
        pieces_due     <= pieces_due + step_pieces.size();
        accepted_count <= accepted_count + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && text_pending.size() > 0) begin
        // a marked item waits until the block has nothing left to give
        if (!(text_pending[0].wait_drain && (took || pieces_due != pieces_seen)) &&
            $urandom_range(99) >= sender_idle_pct(accepted_count)) begin
          head      = text_pending.pop_front();
          nxt_valid = 1'b1;
          nxt_item  = head.item;
        end
      end
      in_valid <= nxt_valid;
      in_item  <= nxt_item;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= receiver_idle_pct(accepted_count);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // monitor: each accepted item is checked against the oldest expectation
  always @(posedge clk) begin
    tps_out_t want;
    if (rst_n && out_valid && out_ready) begin
      pieces_seen <= pieces_seen + 1;
      if (expected_pieces.size() == 0) begin
        $error("unexpected item: byte %0h", out_item.out_byte);
        mismatch_count++;
      end else begin
        want = expected_pieces.pop_front();
        check_field("out_byte", want.out_byte, out_item.out_byte);
        check_field("byte_valid", want.byte_valid, out_item.byte_valid);
        check_field("token_start", want.token_start, out_item.token_start);
        check_field("run_last", want.run_last, out_item.run_last);
        check_field("text_done", want.text_done, out_item.text_done);
        check_field("ws_truncated", want.ws_truncated, out_item.ws_truncated);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] ch, input logic eot);
    pending_byte_t p;
    p.item.in_byte     = ch;
    p.item.end_of_text = eot;
    p.wait_drain       = drain_next;
    drain_next         = 1'b0;
    text_pending.insert(text_pending.size(), p);
  endfunction

  function automatic void add_text(input string s, input logic with_eot);
    for (int i = 0; i < s.len(); i++)
      add_byte(s[i], with_eot && i == s.len() - 1);
  endfunction

  function automatic logic [7:0] pick_letter();
    return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] pick_ws();
    int n;
    n = $urandom_range(5);
    return (n == 0) ? CH_SPACE : 8'(8 + n);
  endfunction

  function automatic logic [7:0] pick_punct();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ws_class(ch) || letter_class(ch) || digit_class(ch));
    return ch;
  endfunction

  // one random text, mostly made of plausible tokens; returns its length in items
  function automatic int gen_text();
    logic [7:0] txt[$];
    string      contr;
    int         ntok;
    int         kind;
    int         len;
    contr = "strvlmd";
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 10);
      repeat (len) txt.insert(txt.size(), 8'($urandom_range(255)));
    end else begin
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
        kind = $urandom_range(99);
        if ($urandom_range(1) && kind < 67) txt.insert(txt.size(), CH_SPACE);
        if (kind < 25) begin
          repeat ($urandom_range(1, 6)) txt.insert(txt.size(), pick_letter());
        end else if (kind < 40) begin
          repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom_range(48, 57)));
        end else if (kind < 52) begin
          repeat ($urandom_range(1, 3)) txt.insert(txt.size(), pick_punct());
        end else if (kind < 67) begin
          txt.insert(txt.size(), CH_APOS);
          txt.insert(txt.size(), contr[$urandom_range(0, 6)]);
          if ($urandom_range(1))
            txt.insert(txt.size(), $urandom_range(1) ? CH_L : pick_letter());
          if ($urandom_range(1)) txt.insert(txt.size(), CH_L);
        end else if (kind < 80) begin
          repeat ($urandom_range(1, 4)) txt.insert(txt.size(), pick_ws());
        end else if (kind < 90) begin
          txt.insert(txt.size(), CH_SPACE);
        end else begin
          txt.insert(txt.size(), 8'($urandom_range(255)));
        end
      end
      case ($urandom_range(7))
        2: txt.insert(txt.size(), CH_SPACE);
        3: begin
          // trailing run, sometimes past the store depth
          txt.insert(txt.size(), CH_SPACE);
          len = $urandom_range(1) ? $urandom_range(WS_DEPTH - 1, WS_DEPTH + 4)
                                  : $urandom_range(1, WS_DEPTH + 6);
          repeat (len) txt.insert(txt.size(), pick_ws());
        end
        4: repeat ($urandom_range(1, 4)) txt.insert(txt.size(), pick_ws());
        5: txt.insert(txt.size(), CH_APOS);
        6: begin
          txt.insert(txt.size(), CH_APOS);
          txt.insert(txt.size(), $urandom_range(1) ? contr[$urandom_range(0, 6)] : pick_letter());
        end
        7: begin
          txt.insert(txt.size(), CH_APOS);
          txt.insert(txt.size(), CH_L);
          if ($urandom_range(1)) txt.insert(txt.size(), CH_L);
        end
        default: ;
      endcase
    end
    foreach (txt[i]) add_byte(txt[i], i == txt.size() - 1);
    return txt.size();
  endfunction

  initial begin
    int random_count;
    bit mid_drain_done;
    random_count   = 0;
    mid_drain_done = 1'b0;

    // lone apostrophe, lone space and lone tab as whole texts
    add_text("'", 1'b1);
    add_text(" ", 1'b1);
    add_byte(8'd9, 1'b1);
    // contractions with the extra l, a spaced contraction, extreme bytes
    add_text("a'lly 'v9", 1'b0);
    add_byte(8'd0, 1'b0);
    add_byte(8'd255, 1'b0);
    // whitespace run of every class, dropped by the letter after it
    add_byte(CH_SPACE, 1'b0);
    for (int c = 9; c <= 13; c++) add_byte(8'(c), 1'b0);
    add_text("x'r", 1'b1);

    drain_next = 1'b1;
    while (random_count < RANDOM_ITEMS) begin
      if (!mid_drain_done && random_count > RANDOM_ITEMS / 2) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      random_count += gen_text();
    end
    total_items = text_pending.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (text_pending.size() > 0 || in_valid || pieces_due != pieces_seen)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_pieces.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* text_pretokenizer_splitter_core.f */
+incdir+hw/rtl
hw/rtl/tps_pkg.sv
hw/rtl/tps_ws_buf.sv
hw/rtl/tps_scan.sv
hw/rtl/tps_out_skid.sv
hw/rtl/text_pretokenizer_splitter_core.sv
tb/text_pretokenizer_splitter_core_test.sv
